// File: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Holds the word formats, action and status codes and parameter defaults.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 32;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_PEEK    = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        value_tag;
        logic signed [31:0] priority_req;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        head_value;
        logic signed [31:0] head_priority;
        logic [6:0]         entry_count;
    } t_out_word;

    // Row-wide command seen by every cell in the same cycle.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// One slot of the sorted row: holds a tag and a priority.
// Depends on spq_pkg for the row command struct.
`default_nettype none

module spq_cell #(
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire spq_pkg::t_cell_cmd   i_cmd,
    input  wire                       i_occupied,
    input  wire        [TAG_BITS-1:0] i_new_tag,
    input  wire signed [31:0]         i_new_prio,
    input  wire                       i_left_take,
    input  wire        [TAG_BITS-1:0] i_left_tag,
    input  wire signed [31:0]         i_left_prio,
    input  wire        [TAG_BITS-1:0] i_right_tag,
    input  wire signed [31:0]         i_right_prio,
    output logic                      o_take,
    output logic       [TAG_BITS-1:0] o_tag,
    output logic signed [31:0]        o_prio
);
    import spq_pkg::*;

    logic        [TAG_BITS-1:0] r_tag;
    logic signed [31:0]         r_prio;

    // The slot gives way to a new entry when it is empty or holds a strictly
    // greater priority; along the sorted row this flag is monotone.
    assign o_take = !i_occupied || (r_prio > i_new_prio);
    assign o_tag  = r_tag;
    assign o_prio = r_prio;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && o_take) begin
            if (i_left_take) begin
                r_tag  <= i_left_tag;
                r_prio <= i_left_prio;
            end else begin
                r_tag  <= i_new_tag;
                r_prio <= i_new_prio;
            end
        end else if (i_cmd.del) begin
            r_tag  <= i_right_tag;
            r_prio <= i_right_prio;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell slots plus the
// occupancy counter and the registered result word. Depends on spq_pkg and spq_cell.
`default_nettype none

// The queue takes one command word per clock cycle (o_busy is always low) and
// presents its result word on o_out in the next cycle, marked by o_valid for
// a single cycle; the receiver must capture it then, as it cannot stall the
// block. The cell row is what makes this possible: every slot compares its
// priority with the incoming one and shifts left, right or loads in the same
// cycle, so the insert position is found and the row rearranged at once.
// Entries with equal priority leave in arrival order. An enqueue on a full
// queue is dropped with status full; dequeue or peek on an empty queue
// reports status empty with zero head fields. Clear empties the queue at once.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire spq_pkg::t_in_word i_in,
    output logic                o_busy,
    output logic                o_valid,
    output spq_pkg::t_out_word  o_out
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                accept;
    logic                full;
    logic                empty;
    t_cell_cmd           cmd;
    logic [TAG_BITS-1:0] new_tag;

    // Per-slot views of the row, wired neighbor to neighbor.
    logic                take     [CAPACITY];
    logic [TAG_BITS-1:0] tag_q    [CAPACITY];
    logic signed [31:0]  prio_q   [CAPACITY];

    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    t_out_word     r_out, n_out;

    // Every word can be taken in the cycle it arrives.
    assign o_busy  = 1'b0;
    assign accept  = i_start && !o_busy;
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign new_tag = TAG_BITS'(i_in.value_tag);

    assign cmd.ins = accept && (i_in.action == ACT_ENQUEUE) && !full;
    assign cmd.del = accept && (i_in.action == ACT_DEQUEUE) && !empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                lt;
        logic [TAG_BITS-1:0] ltag;
        logic signed [31:0]  lprio;
        logic [TAG_BITS-1:0] rtag;
        logic signed [31:0]  rprio;

        // The head slot has no left neighbor, so it always takes the new
        // entry itself; the last slot refills from its own contents, which
        // lie beyond the count after a dequeue and are never read.
        if (g == 0) begin : g_head
            assign lt    = 1'b0;
            assign ltag  = tag_q[g];
            assign lprio = prio_q[g];
        end else begin : g_body
            assign lt    = take[g-1];
            assign ltag  = tag_q[g-1];
            assign lprio = prio_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign rtag  = tag_q[g];
            assign rprio = prio_q[g];
        end else begin : g_mid
            assign rtag  = tag_q[g+1];
            assign rprio = prio_q[g+1];
        end

        spq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_occupied   (CW'(g) < r_count),
            .i_new_tag    (new_tag),
            .i_new_prio   (i_in.priority_req),
            .i_left_take  (lt),
            .i_left_tag   (ltag),
            .i_left_prio  (lprio),
            .i_right_tag  (rtag),
            .i_right_prio (rprio),
            .o_take       (take[g]),
            .o_tag        (tag_q[g]),
            .o_prio       (prio_q[g])
        );
    end

    // Next occupancy and the result word for the accepted command.
    always_comb begin
        n_count             = r_count;
        n_out.status        = ST_OK;
        n_out.head_value    = '0;
        n_out.head_priority = '0;
        unique case (i_in.action)
            ACT_ENQUEUE: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_DEQUEUE, ACT_PEEK: begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.head_value    = 32'(tag_q[0]);
                    n_out.head_priority = prio_q[0];
                    if (i_in.action == ACT_DEQUEUE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.entry_count = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    // Occupancy never runs past the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy exceeds capacity");

    // Every accepted word yields exactly one result word in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted word gave no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result without an accepted word");

    // A dropped enqueue is only reported when the queue is full.
    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

    // An empty report carries zero head fields and a zero count.
    a_empty_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == ST_EMPTY) |->
            (o_out.head_value == '0 && o_out.head_priority == '0
             && r_count == '0))
        else $error("empty status with stale fields");
`endif

endmodule

`default_nettype wire
